/* design/stq_pkg.sv */
// shared types, codes and constants of the sequence track checker
package stq_pkg;

    localparam int MAX_VLQ_BYTES_DEF = 5;

    // parse phases
    localparam logic [2:0] PH_DELTA      = 3'd0;
    localparam logic [2:0] PH_EVENT      = 3'd1;
    localparam logic [2:0] PH_FIRST_DATA = 3'd2;
    localparam logic [2:0] PH_META_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA       = 3'd4;
    localparam logic [2:0] PH_NOTE_DATA  = 3'd5;
    localparam logic [2:0] PH_NOTE_VLQ   = 3'd6;

    // verdict codes
    localparam logic [2:0] V_BUSY   = 3'd0;
    localparam logic [2:0] V_DONE   = 3'd1;
    localparam logic [2:0] V_RUNOFF = 3'd2;
    localparam logic [2:0] V_ESCAPE = 3'd3;
    localparam logic [2:0] V_META   = 3'd4;
    localparam logic [2:0] V_STATUS = 3'd5;

    // byte values
    localparam logic [7:0] BYTE_ESC       = 8'hFE;
    localparam logic [7:0] BYTE_META      = 8'hFF;
    localparam logic [7:0] META_END       = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_LOOP_A    = 8'h2E;
    localparam logic [7:0] META_LOOP_B    = 8'h2D;
    localparam logic [3:0] ST_NOTE        = 4'h9;
    localparam logic [3:0] ST_CTRL        = 4'hB;
    localparam logic [3:0] ST_PROG        = 4'hC;
    localparam logic [3:0] ST_BEND        = 4'hE;
    localparam logic [3:0] ST_NONE        = 4'h0;

    // parser state except the vlq byte count
    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] bytes_left;
        logic [3:0] status_hi;
        logic       escape_pending;
        logic [2:0] held;
    } trk_state_t;

    // one input beat
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } beat_t;

    localparam trk_state_t TRK_STATE_CLEAR = '{
        phase:          PH_DELTA,
        bytes_left:     3'd0,
        status_hi:      ST_NONE,
        escape_pending: 1'b0,
        held:           V_BUSY
    };

endpackage

/* design/stq_step.sv */
// next-state logic of the track parser for one raw byte
module stq_step #(
    parameter int MAX_VLQ_BYTES = stq_pkg::MAX_VLQ_BYTES_DEF,
    parameter int VLQ_CW        = $clog2(MAX_VLQ_BYTES + 1)
) (
    input  stq_pkg::trk_state_t cur_state,
    input  logic [VLQ_CW-1:0]   cur_vlq,
    input  stq_pkg::beat_t      beat,
    output stq_pkg::trk_state_t next_state,
    output logic [VLQ_CW-1:0]   next_vlq
);
    import stq_pkg::*;

    localparam logic [VLQ_CW:0] VLQ_LIMIT = (VLQ_CW + 1)'(MAX_VLQ_BYTES);

    trk_state_t        st;
    logic [VLQ_CW-1:0] vc;
    logic [VLQ_CW:0]   taken;
    logic              vlq_end;
    logic              lb_valid;

    // decision once the first data byte of a channel event is in hand
    function automatic trk_state_t first_data(input trk_state_t s);
        trk_state_t r;
        r = s;
        case (s.status_hi)
            ST_NOTE: r.phase = PH_NOTE_DATA;
            ST_CTRL, ST_BEND:
            begin
                r.bytes_left = 3'd1;
                r.phase      = PH_DATA;
            end
            ST_PROG: r.phase = PH_DELTA;
            default: r.held  = V_STATUS;
        endcase
        return r;
    endfunction

    always_comb
    begin
        st       = beat.start ? TRK_STATE_CLEAR : cur_state;
        vc       = beat.start ? '0 : cur_vlq;
        taken    = {1'b0, vc} + (VLQ_CW + 1)'(1);
        vlq_end  = !beat.data[7] || (taken >= VLQ_LIMIT);
        lb_valid = 1'b0;

        if (st.held == V_BUSY)
        begin
            // unescape
            if (st.escape_pending)
            begin
                st.escape_pending = 1'b0;
                if (beat.data == BYTE_ESC)
                    lb_valid = 1'b1;
                else
                    st.held = V_ESCAPE;
            end
            else if (beat.data == BYTE_ESC)
            begin
                if (beat.last)
                    st.held = V_ESCAPE;
                else
                    st.escape_pending = 1'b1;
            end
            else
            begin
                lb_valid = 1'b1;
            end

            if (lb_valid)
            begin
                case (st.phase)
                    PH_DELTA:
                    begin
                        if (vlq_end)
                        begin
                            vc       = '0;
                            st.phase = PH_EVENT;
                        end
                        else
                        begin
                            vc = taken[VLQ_CW-1:0];
                        end
                    end
                    PH_EVENT:
                    begin
                        if (beat.data == BYTE_META)
                        begin
                            st.phase = PH_META_TYPE;
                        end
                        else if (beat.data[7])
                        begin
                            st.status_hi = beat.data[7:4];
                            st.phase     = PH_FIRST_DATA;
                        end
                        else
                        begin
                            st = first_data(st);
                        end
                    end
                    PH_FIRST_DATA: st = first_data(st);
                    PH_META_TYPE:
                    begin
                        st.status_hi = ST_NONE;
                        if (beat.data == META_END)
                        begin
                            st.held = V_DONE;
                        end
                        else if (beat.data == META_TEMPO)
                        begin
                            st.bytes_left = 3'd3;
                            st.phase      = PH_DATA;
                        end
                        else if (beat.data == META_LOOP_A)
                        begin
                            st.bytes_left = 3'd2;
                            st.phase      = PH_DATA;
                        end
                        else if (beat.data == META_LOOP_B)
                        begin
                            st.bytes_left = 3'd6;
                            st.phase      = PH_DATA;
                        end
                        else
                        begin
                            st.held = V_META;
                        end
                    end
                    PH_DATA:
                    begin
                        if (st.bytes_left <= 3'd1)
                        begin
                            st.bytes_left = 3'd0;
                            st.phase      = PH_DELTA;
                        end
                        else
                        begin
                            st.bytes_left = st.bytes_left - 3'd1;
                        end
                    end
                    PH_NOTE_DATA:
                    begin
                        vc       = '0;
                        st.phase = PH_NOTE_VLQ;
                    end
                    PH_NOTE_VLQ:
                    begin
                        if (vlq_end)
                        begin
                            vc       = '0;
                            st.phase = PH_DELTA;
                        end
                        else
                        begin
                            vc = taken[VLQ_CW-1:0];
                        end
                    end
                    default: st.phase = PH_DELTA;
                endcase
            end

            if (beat.last && st.held == V_BUSY)
                st.held = V_RUNOFF;
        end

        next_state = st;
        next_vlq   = vc;
    end

endmodule

/* design/sequence_track_checker.sv */
// top level of the sequence track checker: input stage, parser state, result register
// an accepted byte beat is registered in the input stage, then its verdict in the result register
// throughput: one byte beat per cycle, limited only by the verdict side stalling
// the parser state is updated by one pass through the step logic per beat
// reset (rst_n low, asynchronous): parser as at a track start, both stages empty
// no clearing pass; beats are taken from the first cycle after reset
module sequence_track_checker #(
    parameter int MAX_VLQ_BYTES = stq_pkg::MAX_VLQ_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // byte channel
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       track_start,
    input  logic       file_end,
    // verdict channel
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic [2:0] verdict
);
    import stq_pkg::*;

    localparam int VLQ_CW = $clog2(MAX_VLQ_BYTES + 1);

    // input stage
    logic       beat_valid_reg;
    beat_t      beat_reg;

    // parser state, written once per beat that moves into the result stage
    trk_state_t        state_reg;
    trk_state_t        state_next;
    logic [VLQ_CW-1:0] vlq_reg;
    logic [VLQ_CW-1:0] vlq_next;

    // result stage
    logic       out_valid_reg;
    logic [2:0] verdict_reg;

    logic advance;
    logic fire;
    logic take;

    // the result register frees up when empty or being taken this cycle
    assign advance    = !out_valid_reg || !verdict_stall;
    // beat moves from the input stage through the step logic
    assign fire       = beat_valid_reg && advance;
    // input stage holds only while its beat cannot move on
    assign byte_stall = beat_valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    stq_step #(
        .MAX_VLQ_BYTES (MAX_VLQ_BYTES),
        .VLQ_CW        (VLQ_CW)
    ) u_step (
        .cur_state  (state_reg),
        .cur_vlq    (vlq_reg),
        .beat       (beat_reg),
        .next_state (state_next),
        .next_vlq   (vlq_next)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_valid_reg <= 1'b0;
        else if (take)
            beat_valid_reg <= 1'b1;
        else if (fire)
            beat_valid_reg <= 1'b0;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg.data  <= data_byte;
            beat_reg.start <= track_start;
            beat_reg.last  <= file_end;
        end
    end

    // parser state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TRK_STATE_CLEAR;
            vlq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= state_next;
                vlq_reg   <= vlq_next;
            end
            if (advance)
                out_valid_reg <= beat_valid_reg;
        end
    end

    // verdict payload is the held verdict after this beat
    always_ff @(posedge clk)
    begin
        if (fire)
            verdict_reg <= state_next.held;
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = verdict_reg;

`ifndef SYNTHESIS
    // a final verdict sticks until a track start
    a_verdict_held: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !beat_reg.start && state_reg.held != V_BUSY
        |=> verdict_reg == $past(state_reg.held))
        else $error("held verdict changed without a track start");

    // the last byte of the file never leaves the track in progress
    a_file_end_final: assert property (@(posedge clk) disable iff (!rst_n)
        fire && beat_reg.last |=> verdict_reg != V_BUSY)
        else $error("verdict still in progress after file end");

    // a shown verdict is always a defined code
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> verdict_reg <= V_STATUS)
        else $error("verdict code out of range");

    // a beat that moves on always lands in the result register
    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("beat lost between input and result stage");
`endif

endmodule
